// File: rtl/sgrht_pkg.sv
`default_nettype none

package sgrht_pkg;

	// Default coordinate width and the fixed width of the size fields.
	localparam int COORD_BITS_DEF = 16;
	localparam int SIZE_BITS      = 15;

	// Width that holds any rectangle edge: origin plus size, with carry and sign.
	function automatic int edge_bits(input int cb);
		return (cb + 1 > SIZE_BITS + 2) ? cb + 1 : SIZE_BITS + 2;
	endfunction

	// Sign of an orientation value; both bits low means zero.
	typedef struct packed {
		logic pos;
		logic neg;
	} sgn_t;

	// Orientation of each rectangle corner against the segment line.
	typedef struct packed {
		sgn_t lb;
		sgn_t rb;
		sgn_t lt;
		sgn_t rt;
	} corner_sgn_t;

	// One endpoint compared against the four rectangle bounds.
	typedef struct packed {
		logic xl_lt;
		logic xl_gt;
		logic xr_lt;
		logic xr_gt;
		logic yb_lt;
		logic yb_gt;
		logic yt_lt;
		logic yt_gt;
	} pt_cmp_t;

	function automatic logic sgn_zero(input sgn_t s);
		return !s.pos && !s.neg;
	endfunction

	// Standard segment meeting test from four orientation signs and the
	// four collinear bounding-box checks.
	function automatic logic segs_meet(input sgn_t o1, input sgn_t o2,
			input sgn_t o3, input sgn_t o4, input logic b1, input logic b2,
			input logic b3, input logic b4);
		return ((o1 != o2) && (o3 != o4)) ||
			(sgn_zero(o1) && b1) || (sgn_zero(o2) && b2) ||
			(sgn_zero(o3) && b3) || (sgn_zero(o4) && b4);
	endfunction

endpackage

`default_nettype wire

// File: rtl/sgrht_prep.sv
`default_nettype none

module sgrht_prep
	import sgrht_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] rect_left,
	input  wire logic signed [COORD_BITS-1:0] rect_bottom,
	input  wire logic        [SIZE_BITS-1:0]  rect_width,
	input  wire logic        [SIZE_BITS-1:0]  rect_height,
	input  wire logic signed [COORD_BITS-1:0] seg_start_x,
	input  wire logic signed [COORD_BITS-1:0] seg_start_y,
	input  wire logic signed [COORD_BITS-1:0] seg_end_x,
	input  wire logic signed [COORD_BITS-1:0] seg_end_y,
	output logic                              valid_s1,
	output logic signed [edge_bits(COORD_BITS)-1:0] l_s1,
	output logic signed [edge_bits(COORD_BITS)-1:0] r_s1,
	output logic signed [edge_bits(COORD_BITS)-1:0] b_s1,
	output logic signed [edge_bits(COORD_BITS)-1:0] t_s1,
	output logic signed [COORD_BITS-1:0]      s0x_s1,
	output logic signed [COORD_BITS-1:0]      s0y_s1,
	output logic signed [COORD_BITS-1:0]      s1x_s1,
	output logic signed [COORD_BITS-1:0]      s1y_s1,
	output logic signed [COORD_BITS:0]        dx_s1,
	output logic signed [COORD_BITS:0]        dy_s1,
	output logic signed [edge_bits(COORD_BITS):0] dlx_s1,
	output logic signed [edge_bits(COORD_BITS):0] drx_s1,
	output logic signed [edge_bits(COORD_BITS):0] dby_s1,
	output logic signed [edge_bits(COORD_BITS):0] dty_s1,
	output logic                              wz_s1,
	output logic                              hz_s1
);

	localparam int EW = edge_bits(COORD_BITS);
	localparam int CW = COORD_BITS + 1;
	localparam int DW = EW + 1;

	logic signed [EW-1:0] l_c, r_c, b_c, t_c;

	always_comb begin
		l_c = EW'(rect_left);
		b_c = EW'(rect_bottom);
		r_c = l_c + EW'($signed({1'b0, rect_width}));
		t_c = b_c + EW'($signed({1'b0, rect_height}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		l_s1   <= l_c;
		r_s1   <= r_c;
		b_s1   <= b_c;
		t_s1   <= t_c;
		s0x_s1 <= seg_start_x;
		s0y_s1 <= seg_start_y;
		s1x_s1 <= seg_end_x;
		s1y_s1 <= seg_end_y;
		dx_s1  <= CW'(seg_end_x) - CW'(seg_start_x);
		dy_s1  <= CW'(seg_end_y) - CW'(seg_start_y);
		dlx_s1 <= DW'(l_c) - DW'(seg_end_x);
		drx_s1 <= DW'(r_c) - DW'(seg_end_x);
		dby_s1 <= DW'(b_c) - DW'(seg_end_y);
		dty_s1 <= DW'(t_c) - DW'(seg_end_y);
		wz_s1  <= (rect_width == '0);
		hz_s1  <= (rect_height == '0);
	end

endmodule

`default_nettype wire

// File: rtl/sgrht_orient.sv
`default_nettype none

module sgrht_orient
	import sgrht_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic signed [COORD_BITS:0]       dx_s1,
	input  wire logic signed [COORD_BITS:0]       dy_s1,
	input  wire logic signed [edge_bits(COORD_BITS):0] dlx_s1,
	input  wire logic signed [edge_bits(COORD_BITS):0] drx_s1,
	input  wire logic signed [edge_bits(COORD_BITS):0] dby_s1,
	input  wire logic signed [edge_bits(COORD_BITS):0] dty_s1,
	output corner_sgn_t                           csgn_s3
);

	localparam int PW = COORD_BITS + 1 + edge_bits(COORD_BITS) + 1;

	// The x term depends only on the corner's x and the y term only on its
	// y, so four products cover all four corners.
	logic signed [PW-1:0] pl_s2, pr_s2, qb_s2, qt_s2;

	always_ff @(posedge clk) begin
		pl_s2 <= PW'(dy_s1) * PW'(dlx_s1);
		pr_s2 <= PW'(dy_s1) * PW'(drx_s1);
		qb_s2 <= PW'(dx_s1) * PW'(dby_s1);
		qt_s2 <= PW'(dx_s1) * PW'(dty_s1);
	end

	always_ff @(posedge clk) begin
		csgn_s3.lb.pos <= pl_s2 > qb_s2;
		csgn_s3.lb.neg <= pl_s2 < qb_s2;
		csgn_s3.rb.pos <= pr_s2 > qb_s2;
		csgn_s3.rb.neg <= pr_s2 < qb_s2;
		csgn_s3.lt.pos <= pl_s2 > qt_s2;
		csgn_s3.lt.neg <= pl_s2 < qt_s2;
		csgn_s3.rt.pos <= pr_s2 > qt_s2;
		csgn_s3.rt.neg <= pr_s2 < qt_s2;
	end

endmodule

`default_nettype wire

// File: rtl/sgrht_decide.sv
`default_nettype none

module sgrht_decide
	import sgrht_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_s1,
	input  wire logic signed [edge_bits(COORD_BITS)-1:0] l_s1,
	input  wire logic signed [edge_bits(COORD_BITS)-1:0] r_s1,
	input  wire logic signed [edge_bits(COORD_BITS)-1:0] b_s1,
	input  wire logic signed [edge_bits(COORD_BITS)-1:0] t_s1,
	input  wire logic signed [COORD_BITS-1:0] s0x_s1,
	input  wire logic signed [COORD_BITS-1:0] s0y_s1,
	input  wire logic signed [COORD_BITS-1:0] s1x_s1,
	input  wire logic signed [COORD_BITS-1:0] s1y_s1,
	input  wire logic                         wz_s1,
	input  wire logic                         hz_s1,
	input  wire corner_sgn_t                  csgn_s3,
	output logic                              done,
	output logic                              hit
);

	localparam int EW = edge_bits(COORD_BITS);

	logic    valid_s2, valid_s3;
	pt_cmp_t p0_s2, p1_s2, p0_s3, p1_s3;
	logic    wz_s2, hz_s2, wz_s3, hz_s3;
	pt_cmp_t p0_c, p1_c;
	logic    hit_c;

	always_comb begin
		p0_c.xl_lt = EW'(s0x_s1) < l_s1;
		p0_c.xl_gt = EW'(s0x_s1) > l_s1;
		p0_c.xr_lt = EW'(s0x_s1) < r_s1;
		p0_c.xr_gt = EW'(s0x_s1) > r_s1;
		p0_c.yb_lt = EW'(s0y_s1) < b_s1;
		p0_c.yb_gt = EW'(s0y_s1) > b_s1;
		p0_c.yt_lt = EW'(s0y_s1) < t_s1;
		p0_c.yt_gt = EW'(s0y_s1) > t_s1;
		p1_c.xl_lt = EW'(s1x_s1) < l_s1;
		p1_c.xl_gt = EW'(s1x_s1) > l_s1;
		p1_c.xr_lt = EW'(s1x_s1) < r_s1;
		p1_c.xr_gt = EW'(s1x_s1) > r_s1;
		p1_c.yb_lt = EW'(s1y_s1) < b_s1;
		p1_c.yb_gt = EW'(s1y_s1) > b_s1;
		p1_c.yt_lt = EW'(s1y_s1) < t_s1;
		p1_c.yt_gt = EW'(s1y_s1) > t_s1;
	end

	always_ff @(posedge clk) begin
		p0_s2 <= p0_c;
		p1_s2 <= p1_c;
		wz_s2 <= wz_s1;
		hz_s2 <= hz_s1;
		p0_s3 <= p0_s2;
		p1_s3 <= p1_s2;
		wz_s3 <= wz_s2;
		hz_s3 <= hz_s2;
	end

	// Edge-side orientations of each endpoint, box checks, and the final OR.
	always_comb begin
		sgn_t ob0, ob1, or0, or1, ot0, ot1, ol0, ol1;
		logic in0, in1;
		logic eb0, eb1, er0, er1, et0, et1, el0, el1;
		logic cx_l, cx_r, cy_b, cy_t;
		logic c_lb, c_rb, c_lt, c_rt;

		// Horizontal edges run left to right, vertical edges bottom to top.
		ob0.pos = !wz_s3 && p0_s3.yb_lt;
		ob0.neg = !wz_s3 && p0_s3.yb_gt;
		ob1.pos = !wz_s3 && p1_s3.yb_lt;
		ob1.neg = !wz_s3 && p1_s3.yb_gt;
		ot0.pos = !wz_s3 && p0_s3.yt_lt;
		ot0.neg = !wz_s3 && p0_s3.yt_gt;
		ot1.pos = !wz_s3 && p1_s3.yt_lt;
		ot1.neg = !wz_s3 && p1_s3.yt_gt;
		or0.pos = !hz_s3 && p0_s3.xr_gt;
		or0.neg = !hz_s3 && p0_s3.xr_lt;
		or1.pos = !hz_s3 && p1_s3.xr_gt;
		or1.neg = !hz_s3 && p1_s3.xr_lt;
		ol0.pos = !hz_s3 && p0_s3.xl_gt;
		ol0.neg = !hz_s3 && p0_s3.xl_lt;
		ol1.pos = !hz_s3 && p1_s3.xl_gt;
		ol1.neg = !hz_s3 && p1_s3.xl_lt;

		in0 = !p0_s3.xl_lt && !p0_s3.xr_gt && !p0_s3.yb_lt && !p0_s3.yt_gt;
		in1 = !p1_s3.xl_lt && !p1_s3.xr_gt && !p1_s3.yb_lt && !p1_s3.yt_gt;

		// Endpoint within the bounding box of each edge.
		eb0 = !p0_s3.xl_lt && !p0_s3.xr_gt && !p0_s3.yb_lt && !p0_s3.yb_gt;
		eb1 = !p1_s3.xl_lt && !p1_s3.xr_gt && !p1_s3.yb_lt && !p1_s3.yb_gt;
		et0 = !p0_s3.xl_lt && !p0_s3.xr_gt && !p0_s3.yt_lt && !p0_s3.yt_gt;
		et1 = !p1_s3.xl_lt && !p1_s3.xr_gt && !p1_s3.yt_lt && !p1_s3.yt_gt;
		er0 = !p0_s3.xr_lt && !p0_s3.xr_gt && !p0_s3.yb_lt && !p0_s3.yt_gt;
		er1 = !p1_s3.xr_lt && !p1_s3.xr_gt && !p1_s3.yb_lt && !p1_s3.yt_gt;
		el0 = !p0_s3.xl_lt && !p0_s3.xl_gt && !p0_s3.yb_lt && !p0_s3.yt_gt;
		el1 = !p1_s3.xl_lt && !p1_s3.xl_gt && !p1_s3.yb_lt && !p1_s3.yt_gt;

		// Corner coordinates within the bounding box of the segment.
		cx_l = (!p0_s3.xl_lt || !p1_s3.xl_lt) && (!p0_s3.xl_gt || !p1_s3.xl_gt);
		cx_r = (!p0_s3.xr_lt || !p1_s3.xr_lt) && (!p0_s3.xr_gt || !p1_s3.xr_gt);
		cy_b = (!p0_s3.yb_lt || !p1_s3.yb_lt) && (!p0_s3.yb_gt || !p1_s3.yb_gt);
		cy_t = (!p0_s3.yt_lt || !p1_s3.yt_lt) && (!p0_s3.yt_gt || !p1_s3.yt_gt);
		c_lb = cx_l && cy_b;
		c_rb = cx_r && cy_b;
		c_lt = cx_l && cy_t;
		c_rt = cx_r && cy_t;

		hit_c = in0 || in1 ||
			segs_meet(ob0, ob1, csgn_s3.lb, csgn_s3.rb, eb0, eb1, c_lb, c_rb) ||
			segs_meet(or0, or1, csgn_s3.rb, csgn_s3.rt, er0, er1, c_rb, c_rt) ||
			segs_meet(ot0, ot1, csgn_s3.lt, csgn_s3.rt, et0, et1, c_lt, c_rt) ||
			segs_meet(ol0, ol1, csgn_s3.lb, csgn_s3.lt, el0, el1, c_lb, c_lt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit <= hit_c;
	end

endmodule

`default_nettype wire

// File: rtl/segment_rectangle_hit_test_core.sv
`default_nettype none

// Segment versus axis-aligned rectangle hit test.
//
// A word is presented on the rectangle and segment ports with start high;
// it is taken at every rising edge where start is high and busy is low.
// Busy is always low: a new word may be issued in every cycle, so the
// sustained rate is one test per clock.
// The answer appears on hit with done high for exactly one cycle,
// and answers leave in the order in which the words were taken.
// The pipeline has four stages: edge and difference formation, four
// signed products of the orientation terms (the deepest path, one
// multiplier each) beside the endpoint bound compares, product
// comparison, and the final OR of edge tests and endpoint-inside checks.
// The receiver has no way to hold results off, so there is no stall path
// and nothing in flight ever waits.
// An asynchronous reset on arst_n clears the stage valid bits, so no done
// pulse follows reset until new words are issued; data registers are not
// reset. Coordinates are COORD_BITS wide two's complement; the right and
// top edges are formed at full precision and never wrap.
module segment_rectangle_hit_test_core
	import sgrht_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] rect_left,
	input  wire logic signed [COORD_BITS-1:0] rect_bottom,
	input  wire logic        [SIZE_BITS-1:0]  rect_width,
	input  wire logic        [SIZE_BITS-1:0]  rect_height,
	input  wire logic signed [COORD_BITS-1:0] seg_start_x,
	input  wire logic signed [COORD_BITS-1:0] seg_start_y,
	input  wire logic signed [COORD_BITS-1:0] seg_end_x,
	input  wire logic signed [COORD_BITS-1:0] seg_end_y,
	output logic                              done,
	output logic                              hit
);

	localparam int EW = edge_bits(COORD_BITS);

	logic                        valid_s1;
	logic signed [EW-1:0]        l_s1, r_s1, b_s1, t_s1;
	logic signed [COORD_BITS-1:0] s0x_s1, s0y_s1, s1x_s1, s1y_s1;
	logic signed [COORD_BITS:0]  dx_s1, dy_s1;
	logic signed [EW:0]          dlx_s1, drx_s1, dby_s1, dty_s1;
	logic                        wz_s1, hz_s1;
	corner_sgn_t                 csgn_s3;

	// Every stage advances each cycle, so the input side never waits.
	assign busy = 1'b0;

	sgrht_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.rect_left   (rect_left),
		.rect_bottom (rect_bottom),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.valid_s1    (valid_s1),
		.l_s1        (l_s1),
		.r_s1        (r_s1),
		.b_s1        (b_s1),
		.t_s1        (t_s1),
		.s0x_s1      (s0x_s1),
		.s0y_s1      (s0y_s1),
		.s1x_s1      (s1x_s1),
		.s1y_s1      (s1y_s1),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.dlx_s1      (dlx_s1),
		.drx_s1      (drx_s1),
		.dby_s1      (dby_s1),
		.dty_s1      (dty_s1),
		.wz_s1       (wz_s1),
		.hz_s1       (hz_s1)
	);

	sgrht_orient #(
		.COORD_BITS(COORD_BITS)
	) u_orient (
		.clk     (clk),
		.dx_s1   (dx_s1),
		.dy_s1   (dy_s1),
		.dlx_s1  (dlx_s1),
		.drx_s1  (drx_s1),
		.dby_s1  (dby_s1),
		.dty_s1  (dty_s1),
		.csgn_s3 (csgn_s3)
	);

	sgrht_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.l_s1     (l_s1),
		.r_s1     (r_s1),
		.b_s1     (b_s1),
		.t_s1     (t_s1),
		.s0x_s1   (s0x_s1),
		.s0y_s1   (s0y_s1),
		.s1x_s1   (s1x_s1),
		.s1y_s1   (s1y_s1),
		.wz_s1    (wz_s1),
		.hz_s1    (hz_s1),
		.csgn_s3  (csgn_s3),
		.done     (done),
		.hit      (hit)
	);

endmodule

`default_nettype wire
